/* sv/fsa_pkg.sv */
`timescale 1ns / 1ps
package fsa_pkg;
	localparam int unsigned NUM_W = 32;
	localparam int unsigned DEN_W = 31;
	localparam int unsigned PROD_W = 64;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_ZERO  = 2'd1,
		ERR_RANGE = 2'd2
	} err_t;

	typedef struct packed {
		logic load;
		logic mul_lo;
		logic mul_hi;
		logic sum;
		logic gcd_start;
		logic div_start;
		logic commit;
	} fsa_cmd_t;

	typedef struct packed {
		logic gcd_done;
		logic div_done;
		logic zero_den;
	} fsa_sts_t;
endpackage

/* sv/fraction_sum_accumulator.sv */
`timescale 1ns / 1ps
// channel | dir | fields
// s_axis  | in  | tdata: term_numerator[31:0], term_denominator[62:32]; tuser: last_term
// m_axis  | out | tdata: sum_numerator[31:0], sum_denominator[62:32]; tuser: sum_complete
//         |     |   then error_code[2:1]
// One item at a time: after accept, the term passes the multiply, sum, gcd and divide
// states, one binary gcd step per cycle (fewer steps for small values), then reaches m_axis.
// A zero denominator skips straight to the output state. Reset sets the sum to 0/1.
// Input is taken whenever the controller is idle; a result still waiting in m_axis
// stalls the next one in its final state until the register is taken.
module fraction_sum_accumulator import fsa_pkg::*; #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // term_numerator, term_denominator
	input  logic        s_axis_tuser,  // last_term
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // sum_numerator, sum_denominator
	output logic [2:0]  m_axis_tuser   // sum_complete, error_code
);
	fsa_cmd_t cmd;
	fsa_sts_t sts;
	logic busy, in_fire, out_free;
	logic signed [NUM_W-1:0] res_num;
	logic [DEN_W-1:0] res_den;
	logic res_last;
	err_t res_err;
	logic ov_q;

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_free = !ov_q || m_axis_tready;
	assign m_axis_tvalid = ov_q;

	fsa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_free(out_free),
		.sts(sts), .cmd(cmd), .busy(busy)
	);

	fsa_dp #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_num(s_axis_tdata[31:0]), .in_den(s_axis_tdata[62:32]), .in_last(s_axis_tuser),
		.sts(sts), .res_num(res_num), .res_den(res_den), .res_last(res_last),
		.res_err(res_err)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (cmd.commit) ov_q <= 1'b1;
		else if (m_axis_tready) ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			m_axis_tdata <= {1'b0, res_den, res_num};
			m_axis_tuser <= {res_err, res_last};
		end
	end
endmodule

/* sv/fsa_ctrl.sv */
`timescale 1ns / 1ps
module fsa_ctrl import fsa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_fire,
	input  logic     out_free,
	input  fsa_sts_t sts,
	output fsa_cmd_t cmd,
	output logic     busy
);
	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_MLO  = 8'b0000_0010,
		S_MHI  = 8'b0000_0100,
		S_SUM  = 8'b0000_1000,
		S_GCD  = 8'b0001_0000,
		S_DIV  = 8'b0010_0000,
		S_OUT  = 8'b0100_0000,
		S_GST  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_fire;
				if (in_fire) state_d = S_MLO;
			end
			S_MLO: begin
				if (sts.zero_den) state_d = S_OUT;
				else begin
					cmd.mul_lo = 1'b1;
					state_d = S_MHI;
				end
			end
			S_MHI: begin
				cmd.mul_hi = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_GST;
			end
			S_GST: begin
				cmd.gcd_start = 1'b1;
				state_d = S_GCD;
			end
			S_GCD: begin
				if (sts.gcd_done) begin
					cmd.div_start = 1'b1;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_done) state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> state_q == S_IDLE) else $error("commit did not return idle");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !busy) else $error("load while busy");
endmodule

/* sv/fsa_dp.sv */
`timescale 1ns / 1ps
module fsa_dp import fsa_pkg::*; #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fsa_cmd_t                cmd,
	input  logic signed [NUM_W-1:0] in_num,
	input  logic [DEN_W-1:0]        in_den,
	input  logic                    in_last,
	output fsa_sts_t                sts,
	output logic signed [NUM_W-1:0] res_num,
	output logic [DEN_W-1:0]        res_den,
	output logic                    res_last,
	output err_t                    res_err
);
	localparam logic [PROD_W-1:0] LIM = PROD_W'(1) << (VALUE_WIDTH - 1);
	localparam int unsigned CW = 7;

	logic signed [NUM_W-1:0] tn_q, rn_q;
	logic [DEN_W-1:0]        td_q, rd_q;
	logic                    last_q;
	logic signed [PROD_W-1:0] p1_q, p2_q;
	logic [PROD_W-1:0]       pd_q;
	logic                    neg_q;
	logic [PROD_W-1:0]       mag_q, den_q;
	// gcd: binary, one step a cycle
	logic [PROD_W-1:0]       ga_q, gb_q;
	logic [CW-1:0]           gk_q;
	logic                    grun_q;
	// divider: restoring, two quotients shared loop
	logic [PROD_W-1:0]       dvs_q, qn_q, qd_q, remn_q, remd_q;
	logic [CW-1:0]           dc_q;
	logic                    drun_q, ddone_q;
	logic [PROD_W-1:0]       rmn, rmd, dfn, dfd;
	logic                    gdone;

	assign sts.zero_den = (td_q == '0);
	assign gdone = grun_q && (gb_q == '0);
	assign sts.gcd_done = gdone;
	assign sts.div_done = ddone_q;

	always_comb begin
		rmn = {remn_q[PROD_W-2:0], qn_q[PROD_W-1]};
		rmd = {remd_q[PROD_W-2:0], qd_q[PROD_W-1]};
		dfn = rmn - dvs_q;
		dfd = rmd - dvs_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tn_q <= in_num;
			td_q <= in_den;
			last_q <= in_last;
		end
		if (cmd.mul_lo) p1_q <= PROD_W'(tn_q) * $signed({1'b0, rd_q});
		if (cmd.mul_hi) begin
			p2_q <= PROD_W'(rn_q) * $signed({1'b0, td_q});
			pd_q <= PROD_W'(td_q) * PROD_W'(rd_q);
		end
		if (cmd.sum) begin
			neg_q <= (p1_q + p2_q) < 0;
			mag_q <= ((p1_q + p2_q) < 0) ? PROD_W'(-(p1_q + p2_q)) : PROD_W'(p1_q + p2_q);
			den_q <= pd_q;
		end
		if (cmd.gcd_start) begin
			ga_q <= mag_q;
			gb_q <= den_q;
			gk_q <= '0;
		end else if (grun_q && gb_q != '0) begin
			if (ga_q == '0) begin
				ga_q <= gb_q;
				gb_q <= '0;
			end else if (!ga_q[0] && !gb_q[0]) begin
				ga_q <= ga_q >> 1;
				gb_q <= gb_q >> 1;
				gk_q <= gk_q + CW'(1);
			end else if (!ga_q[0]) ga_q <= ga_q >> 1;
			else if (!gb_q[0]) gb_q <= gb_q >> 1;
			else if (ga_q >= gb_q) ga_q <= (ga_q - gb_q) >> 1;
			else begin
				gb_q <= ga_q;
				ga_q <= (gb_q - ga_q) >> 1;
			end
		end
		if (cmd.div_start) begin
			dvs_q <= ga_q << gk_q;
			qn_q <= mag_q;
			qd_q <= den_q;
			remn_q <= '0;
			remd_q <= '0;
			dc_q <= '0;
		end else if (drun_q) begin
			remn_q <= (rmn >= dvs_q) ? dfn : rmn;
			remd_q <= (rmd >= dvs_q) ? dfd : rmd;
			qn_q <= {qn_q[PROD_W-2:0], rmn >= dvs_q};
			qd_q <= {qd_q[PROD_W-2:0], rmd >= dvs_q};
			dc_q <= dc_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grun_q <= 1'b0;
			drun_q <= 1'b0;
			ddone_q <= 1'b0;
		end else begin
			if (cmd.gcd_start) grun_q <= 1'b1;
			else if (gdone) grun_q <= 1'b0;
			ddone_q <= drun_q && dc_q == CW'(PROD_W - 1);
			if (cmd.div_start) drun_q <= 1'b1;
			else if (dc_q == CW'(PROD_W - 1)) drun_q <= 1'b0;
		end
	end

	logic [PROD_W-1:0] fn, fd;
	logic              ok;
	always_comb begin
		fn = (mag_q == '0) ? '0 : qn_q;
		fd = (mag_q == '0) ? PROD_W'(1) : qd_q;
		ok = (fd <= LIM - 1) && (neg_q ? fn <= LIM : fn <= LIM - 1);
		res_last = last_q;
		if (sts.zero_den) begin
			res_err = ERR_ZERO;
			res_num = rn_q;
			res_den = rd_q;
		end else if (!ok) begin
			res_err = ERR_RANGE;
			res_num = rn_q;
			res_den = rd_q;
		end else begin
			res_err = ERR_OK;
			res_num = neg_q ? -NUM_W'(fn) : NUM_W'(fn);
			res_den = DEN_W'(fd);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rn_q <= '0;
			rd_q <= DEN_W'(1);
		end else if (cmd.commit) begin
			if (last_q) begin
				rn_q <= '0;
				rd_q <= DEN_W'(1);
			end else begin
				rn_q <= res_num;
				rd_q <= res_den;
			end
		end
	end

	a_den_nz: assert property (@(posedge clk) disable iff (!arst_n) rd_q != '0)
		else $error("running denominator zero");
	a_gcd_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> gdone) else $error("divide before gcd done");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(grun_q && drun_q)) else $error("gcd and divider both running");
endmodule
